// ===== sv/pvg_pkg.sv =====
// Shared types, constants and the log table for the partisan voter event block.
package pvg_pkg;

  // Fixed field widths
  localparam int POP_W     = 12;
  localparam int ZEAL_W    = 11;
  localparam int NOISE_W   = 16;
  localparam int HOR_W     = 32;
  localparam int UNI_W     = 32;
  localparam int TIME_W    = 56;
  localparam int AGENT_W   = 12;
  localparam int BIAS_W    = NOISE_W + 1;
  localparam int LOG_W     = 21;
  localparam int TWO_W     = POP_W + 1;
  localparam int SHIFT_W   = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [BIAS_W-1:0] ONE_Q16 = BIAS_W'(65536);
  localparam logic [15:0]       LN2_Q16 = 16'd45426;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Register reset values
  localparam logic [POP_W-1:0]   POP_RST   = 12'd100;
  localparam logic [ZEAL_W-1:0]  ZEAL_RST  = 11'd10;
  localparam logic [NOISE_W-1:0] NOISE_RST = 16'd0;
  localparam logic [HOR_W-1:0]   HOR_RST   = 32'd10000000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POPULATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZEALOTS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HORIZON    = 2'd3;

  // Run end codes
  localparam logic [1:0] END_RUNNING  = 2'd0;
  localparam logic [1:0] END_FIXATED  = 2'd1;
  localparam logic [1:0] END_HORIZON  = 2'd2;
  localparam logic [1:0] END_STALL    = 2'd3;

  // Event codes
  localparam logic [1:0] EV_MP_TO_PLUS  = 2'd0;
  localparam logic [1:0] EV_PP_TO_MINUS = 2'd1;
  localparam logic [1:0] EV_PM_TO_MINUS = 2'd2;
  localparam logic [1:0] EV_MM_TO_PLUS  = 2'd3;

  typedef struct packed {
    logic [UNI_W-1:0] exp_uniform;
    logic [UNI_W-1:0] select_uniform;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         run_end;
    logic [1:0]         event_kind;
    logic [TIME_W-1:0]  sim_time;
    logic [AGENT_W-1:0] agents_plus_plus_pref;
    logic [AGENT_W-1:0] agents_plus_minus_pref;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL1,
    OP_MUL2,
    OP_SUM,
    OP_NORM,
    OP_LOG1,
    OP_LOG2,
    OP_NUM,
    OP_DIV,
    OP_HI,
    OP_SEL,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] end_code;
  } dp_cmd_t;

  typedef struct packed {
    logic total_zero;
    logic norm_done;
    logic div_last;
    logic fixated;
    logic horizon_hit;
  } dp_stat_t;

  // ln(1+i/16) in Q16, i = 0..16
  function automatic logic [15:0] ln1p_q16(input logic [4:0] idx);
    logic [15:0] v;
    unique case (idx)
      5'd0:    v = 16'd0;
      5'd1:    v = 16'd3973;
      5'd2:    v = 16'd7719;
      5'd3:    v = 16'd11262;
      5'd4:    v = 16'd14624;
      5'd5:    v = 16'd17821;
      5'd6:    v = 16'd20870;
      5'd7:    v = 16'd23783;
      5'd8:    v = 16'd26573;
      5'd9:    v = 16'd29248;
      5'd10:   v = 16'd31818;
      5'd11:   v = 16'd34292;
      5'd12:   v = 16'd36675;
      5'd13:   v = 16'd38975;
      5'd14:   v = 16'd41196;
      5'd15:   v = 16'd43345;
      5'd16:   v = 16'd45426;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/pvg_datapath.sv =====
// Datapath: config registers, counts, weights, log, divider, selection, result register.
module pvg_datapath #(
  parameter int COUNT_BITS     = 12,
  parameter int TIME_FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pvg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pvg_pkg::HOR_W-1:0]    cfg_wdata_i,
  input  pvg_pkg::in_item_t            in_data_i,
  input  pvg_pkg::dp_cmd_t             cmd_i,
  output pvg_pkg::dp_stat_t            stat_o,
  output pvg_pkg::out_item_t           out_data_o
);
  import pvg_pkg::*;

  localparam int CB       = COUNT_BITS;
  localparam int SUM_W    = CB + 1;
  localparam int PZ_W     = ((SUM_W > ZEAL_W) ? SUM_W : ZEAL_W) + 1;
  localparam int PROD_W   = CB + PZ_W;
  localparam int WT_W     = PROD_W + BIAS_W;
  localparam int TOT_W    = WT_W + 2;
  localparam int TOT_HI_W = TOT_W - 32;
  localparam int HI_W     = TOT_W + 1;
  localparam int NUM_W    = LOG_W + TWO_W;
  localparam int ND       = NUM_W + TIME_FRAC_BITS;
  localparam int CNT_W    = $clog2(ND + 1);
  localparam int TSUM_W   = ((ND > TIME_W) ? ND : TIME_W) + 1;
  localparam int SP_W     = (CB > POP_W) ? CB : POP_W;
  localparam int EXT_W    = (CB > AGENT_W) ? CB : AGENT_W;
  localparam int CMAX_INT = (1 << CB) - 1;
  localparam int RST_RAW  = int'(POP_RST) - int'(ZEAL_RST);
  localparam int RST_SPAN = (RST_RAW > CMAX_INT) ? CMAX_INT : RST_RAW;
  localparam logic [CB-1:0] RST_MP = CB'(RST_SPAN / 2);
  localparam logic [CB-1:0] RST_MM = CB'(RST_SPAN - RST_SPAN / 2);

  logic [POP_W-1:0]   pop_q;
  logic [ZEAL_W-1:0]  zeal_q;
  logic [NOISE_W-1:0] noise_q;
  logic [HOR_W-1:0]   hor_q;

  logic [CB-1:0] pp_q, pm_q, mp_q, mm_q;
  logic [TIME_W-1:0] time_q;

  logic [UNI_W-1:0]   u_q, r2_q;
  logic [SHIFT_W-1:0] sh_q;
  logic [1:0]         kind_q;
  logic [PROD_W-1:0]  pr0_q, pr1_q, pr2_q, pr3_q;
  logic [WT_W-1:0]    w0_q, w1_q, w2_q, w3_q;
  logic [TOT_W-1:0]   cum1_q, cum2_q, tot_q;
  logic [15:0]        base_q;
  logic [31:0]        dprod_q;
  logic [LOG_W-1:0]   lnk_q, l_q;
  logic [ND-1:0]      dvd_q;
  logic [TOT_W-1:0]   rem_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [63:0]        pa_q;
  logic [32+TOT_HI_W-1:0] pb_q;
  logic [HI_W-1:0]    hi_q;
  logic               lo_zero_q;
  out_item_t          out_q;

  // span of free agents
  logic [POP_W-1:0] s_raw;
  logic [SP_W-1:0]  s_ext, cmax_ext;
  logic [CB-1:0]    span_c;
  logic [SUM_W-1:0] p_sum, m_sum;
  logic [PZ_W-1:0]  pz;
  logic [BIAS_W-1:0] up_b, dn_b;
  logic [TWO_W-1:0] two_nm1;
  logic [4:0]       idx;
  logic [15:0]      frac;
  logic [TOT_W:0]   rem_sh;
  logic [TSUM_W-1:0] tsum;
  logic             le0, le1, le2;
  logic [1:0]       kind_c;
  logic [EXT_W-1:0] pp_ext, pm_ext;

  always_comb begin
    s_raw    = (pop_q > POP_W'(zeal_q)) ? pop_q - POP_W'(zeal_q) : '0;
    s_ext    = SP_W'(s_raw);
    cmax_ext = SP_W'({CB{1'b1}});
    span_c   = CB'((s_ext > cmax_ext) ? cmax_ext : s_ext);
    p_sum    = SUM_W'(pp_q) + SUM_W'(pm_q);
    m_sum    = SUM_W'(mp_q) + SUM_W'(mm_q);
    pz       = PZ_W'(p_sum) + PZ_W'(zeal_q);
    up_b     = ONE_Q16 + BIAS_W'(noise_q);
    dn_b     = ONE_Q16 - BIAS_W'(noise_q);
    two_nm1  = (pop_q != '0) ? {pop_q - POP_W'(1), 1'b0} : '0;
    idx      = {1'b0, u_q[30:27]};
    frac     = u_q[26:11];
    rem_sh   = {rem_q, dvd_q[ND-1]};
    tsum     = TSUM_W'(time_q) + TSUM_W'(dvd_q);
    // r2*total <= cum*2^32
    le0 = (hi_q < HI_W'(w0_q)) || ((hi_q == HI_W'(w0_q)) && lo_zero_q);
    le1 = (hi_q < HI_W'(cum1_q)) || ((hi_q == HI_W'(cum1_q)) && lo_zero_q);
    le2 = (hi_q < HI_W'(cum2_q)) || ((hi_q == HI_W'(cum2_q)) && lo_zero_q);
    if ((w0_q != '0) && le0)      kind_c = EV_MP_TO_PLUS;
    else if ((w1_q != '0) && le1) kind_c = EV_PP_TO_MINUS;
    else if ((w2_q != '0) && le2) kind_c = EV_PM_TO_MINUS;
    else                          kind_c = EV_MM_TO_PLUS;
    pp_ext = EXT_W'(pp_q);
    pm_ext = EXT_W'(pm_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop_q   <= POP_RST;
      zeal_q  <= ZEAL_RST;
      noise_q <= NOISE_RST;
      hor_q   <= HOR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_POPULATION: pop_q   <= cfg_wdata_i[POP_W-1:0];
        CFG_ZEALOTS:    zeal_q  <= cfg_wdata_i[ZEAL_W-1:0];
        CFG_NOISE:      noise_q <= cfg_wdata_i[NOISE_W-1:0];
        CFG_HORIZON:    hor_q   <= cfg_wdata_i;
        default:        ;
      endcase
    end
  end

  // run state: counts and time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_q   <= '0;
      pm_q   <= '0;
      mp_q   <= RST_MP;
      mm_q   <= RST_MM;
      time_q <= '0;
    end else begin
      case (cmd_i.op)
        OP_HI: time_q <= (tsum > TSUM_W'(TIME_MAX)) ? TIME_MAX : TIME_W'(tsum);
        OP_SEL: begin
          case (kind_c)
            EV_MP_TO_PLUS: if (mp_q != '0) begin
              mp_q <= mp_q - CB'(1); pp_q <= pp_q + CB'(1);
            end
            EV_PP_TO_MINUS: if (pp_q != '0) begin
              pp_q <= pp_q - CB'(1); mp_q <= mp_q + CB'(1);
            end
            EV_PM_TO_MINUS: if (pm_q != '0) begin
              pm_q <= pm_q - CB'(1); mm_q <= mm_q + CB'(1);
            end
            default: if (mm_q != '0) begin
              mm_q <= mm_q - CB'(1); pm_q <= pm_q + CB'(1);
            end
          endcase
        end
        OP_EMIT: if (cmd_i.end_code != END_RUNNING) begin
          pp_q   <= '0;
          pm_q   <= '0;
          mp_q   <= span_c >> 1;
          mm_q   <= span_c - (span_c >> 1);
          time_q <= '0;
        end
        default: ;
      endcase
    end
  end

  // arithmetic work registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        u_q    <= (in_data_i.exp_uniform == '0) ? UNI_W'(1) : in_data_i.exp_uniform;
        r2_q   <= in_data_i.select_uniform;
        sh_q   <= '0;
        kind_q <= EV_MP_TO_PLUS;
      end
      OP_MUL1: begin
        pr0_q <= PROD_W'(mp_q) * PROD_W'(pz);
        pr1_q <= PROD_W'(pp_q) * PROD_W'(m_sum);
        pr2_q <= PROD_W'(pm_q) * PROD_W'(m_sum);
        pr3_q <= PROD_W'(mm_q) * PROD_W'(pz);
      end
      OP_MUL2: begin
        w0_q <= WT_W'(pr0_q) * WT_W'(up_b);
        w1_q <= WT_W'(pr1_q) * WT_W'(dn_b);
        w2_q <= WT_W'(pr2_q) * WT_W'(up_b);
        w3_q <= WT_W'(pr3_q) * WT_W'(dn_b);
      end
      OP_SUM: begin
        cum1_q <= TOT_W'(w0_q) + TOT_W'(w1_q);
        cum2_q <= TOT_W'(w0_q) + TOT_W'(w1_q) + TOT_W'(w2_q);
        tot_q  <= TOT_W'(w0_q) + TOT_W'(w1_q) + TOT_W'(w2_q) + TOT_W'(w3_q);
      end
      OP_NORM: begin
        u_q  <= u_q << 1;
        sh_q <= sh_q + SHIFT_W'(1);
      end
      OP_LOG1: begin
        base_q  <= ln1p_q16(idx);
        dprod_q <= 32'(ln1p_q16(idx + 5'd1) - ln1p_q16(idx)) * 32'(frac);
        lnk_q   <= LOG_W'(LOG_W'(sh_q) + LOG_W'(1)) * LOG_W'(LN2_Q16);
      end
      OP_LOG2: l_q <= lnk_q - (LOG_W'(base_q) + LOG_W'(dprod_q[31:16]));
      OP_NUM: begin
        dvd_q <= ND'(NUM_W'(l_q) * NUM_W'(two_nm1)) << TIME_FRAC_BITS;
        rem_q <= '0;
        cnt_q <= CNT_W'(ND);
        pa_q  <= 64'(r2_q) * 64'(tot_q[31:0]);
        pb_q  <= (32+TOT_HI_W)'(r2_q) * (32+TOT_HI_W)'(tot_q[TOT_W-1:32]);
      end
      OP_DIV: begin
        if (rem_sh >= {1'b0, tot_q}) begin
          rem_q <= TOT_W'(rem_sh - {1'b0, tot_q});
          dvd_q <= {dvd_q[ND-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh[TOT_W-1:0];
          dvd_q <= {dvd_q[ND-2:0], 1'b0};
        end
        cnt_q <= cnt_q - CNT_W'(1);
      end
      OP_HI: begin
        hi_q      <= HI_W'(pb_q) + HI_W'(pa_q[63:32]);
        lo_zero_q <= (pa_q[31:0] == '0);
      end
      OP_SEL: kind_q <= kind_c;
      OP_EMIT: begin
        out_q.run_end                <= cmd_i.end_code;
        out_q.event_kind             <= kind_q;
        out_q.sim_time               <= time_q;
        out_q.agents_plus_plus_pref  <= pp_ext[AGENT_W-1:0];
        out_q.agents_plus_minus_pref <= pm_ext[AGENT_W-1:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    stat_o.total_zero  = (tot_q == '0);
    stat_o.norm_done   = u_q[UNI_W-1];
    stat_o.div_last    = (cnt_q == CNT_W'(1));
    stat_o.fixated     = (p_sum == SUM_W'(span_c));
    stat_o.horizon_hit = ({1'b0, time_q} >= ((TIME_W+1)'(hor_q) << TIME_FRAC_BITS));
  end

  assign out_data_o = out_q;

endmodule

// ===== sv/pvg_ctrl.sv =====
// Controller: sequences one event through the datapath and owns the handshakes.
module pvg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  pvg_pkg::dp_stat_t stat_i,
  output pvg_pkg::dp_cmd_t  cmd_o
);
  import pvg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_W1, S_W2, S_WSUM, S_TEST, S_NORM, S_LOG1, S_LOG2,
    S_NUM, S_DIV, S_HI, S_SEL, S_FIN, S_EMIT
  } state_e;

  state_e     state_q, state_d;
  logic       pass2_q, pass2_d;
  logic [1:0] end_q, end_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  always_comb begin
    out_free    = !out_valid_q || out_ready_i;
    state_d     = state_q;
    pass2_d     = pass2_q;
    end_d       = end_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.op       = OP_NONE;
    cmd_o.end_code = end_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) begin
        cmd_o.op = OP_LOAD;
        pass2_d  = 1'b0;
        state_d  = S_W1;
      end
      S_W1: begin
        cmd_o.op = OP_MUL1;
        state_d  = S_W2;
      end
      S_W2: begin
        cmd_o.op = OP_MUL2;
        state_d  = S_WSUM;
      end
      S_WSUM: begin
        cmd_o.op = OP_SUM;
        state_d  = pass2_q ? S_FIN : S_TEST;
      end
      S_TEST: begin
        if (stat_i.total_zero) begin
          end_d   = END_STALL;
          state_d = S_EMIT;
        end else begin
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        if (stat_i.norm_done) state_d = S_LOG1;
        else cmd_o.op = OP_NORM;
      end
      S_LOG1: begin
        cmd_o.op = OP_LOG1;
        state_d  = S_LOG2;
      end
      S_LOG2: begin
        cmd_o.op = OP_LOG2;
        state_d  = S_NUM;
      end
      S_NUM: begin
        cmd_o.op = OP_NUM;
        state_d  = S_DIV;
      end
      S_DIV: begin
        cmd_o.op = OP_DIV;
        if (stat_i.div_last) state_d = S_HI;
      end
      S_HI: begin
        cmd_o.op = OP_HI;
        state_d  = S_SEL;
      end
      S_SEL: begin
        cmd_o.op = OP_SEL;
        pass2_d  = 1'b1;
        state_d  = S_W1;
      end
      S_FIN: begin
        if (stat_i.fixated)          end_d = END_FIXATED;
        else if (stat_i.total_zero)  end_d = END_STALL;
        else if (stat_i.horizon_hit) end_d = END_HORIZON;
        else                         end_d = END_RUNNING;
        state_d = S_EMIT;
      end
      S_EMIT: if (out_free) begin
        cmd_o.op    = OP_EMIT;
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pass2_q     <= 1'b0;
      end_q       <= END_RUNNING;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass2_q     <= pass2_d;
      end_q       <= end_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/partisan_voter_gillespie_step.sv =====
// Top level of the partisan voter Gillespie event block.
// One input transaction carries two Q0.32 uniforms (waiting time, event pick)
// and causes exactly one result transaction: run end code, event kind, the
// elapsed time in Q40.16 and the two plus-holding counts after the event.
// Both channels are valid/ready; config registers are written through a
// plain write port (cfg_we_i, cfg_idx_i, cfg_wdata_i), which the user must
// drive only while the block idles; the block itself does not enforce this.
// After input accept the block forms the weights, normalises the waiting-time
// uniform r1, takes its log, divides, picks the event and forms the weights
// again for the end checks before it emits; a zero total rate skips the event.
// The restoring divider (one quotient bit per cycle, 50 bits by default) and
// the one-bit-a-cycle normalisation of r1 take most of the block's time.
// One transaction is worked on at a time; the next is taken the cycle after
// the result has moved into the output register, even if that result is
// still waiting on a stalled receiver. A stalled receiver holds the block in
// its final state until the output register frees up.
// Reset loads the register defaults and starts a run: plus counts zero,
// minus counts split from N-Z, time zero. Each run end reinitialises so.
module partisan_voter_gillespie_step #(
  parameter int COUNT_BITS     = 12,
  parameter int TIME_FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pvg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pvg_pkg::HOR_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  pvg_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output pvg_pkg::out_item_t            out_data_o
);
  import pvg_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pvg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  pvg_datapath #(
    .COUNT_BITS     (COUNT_BITS),
    .TIME_FRAC_BITS (TIME_FRAC_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_data_o  (out_data_o)
  );

  // An accepted transaction always occupies the sequencer for the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted twice in a row");

  // A result is only produced from the last step, which hands back to idle.
  a_idle_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result raised outside the final step");

  // The datapath never emits while the previous result is still held.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == OP_EMIT) |-> (!out_valid_o || out_ready_i))
    else $error("result register overwritten");

endmodule
